// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

// File: hw/rtl/nfpa_pkg.sv
// ----------------------------------------------------------------------------
// Next-fit page allocator package
// Heap geometry, field widths and the operation and status codes.
// ----------------------------------------------------------------------------
package nfpa_pkg;

    localparam int NUM_PAGES  = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int ID_BITS    = 16;

    localparam int OP_W     = 1;
    localparam int SIZE_W   = 23;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int START_W  = 10;
    localparam int COUNT_W  = 11;

    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int CNT_W      = $clog2(NUM_PAGES + 1);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int REQ_W      = SIZE_W - PAGE_SHIFT + 1;
    localparam int CMP_W      = (CNT_W > REQ_W) ? CNT_W : REQ_W;

    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTHING   = 2'd3;

endpackage

// File: hw/rtl/nfpa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module nfpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hw/rtl/next_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// Next-fit page allocator
// Owner table in one RAM, next-fit search pointer and allocation id counter.
//
// Channel   Valid      Stall      Fields
// input     in_valid   in_stall   operation, size_bytes, page_index
// output    out_valid  out_stall  status, start_page, page_count
//
// After reset the owner table is cleared, one page a cycle, while in_stall
// stays high. An allocate scans from the search pointer, then writes the
// allocated pages; a free scans the run owned at page_index and clears it;
// a zero size goes straight to the response. Scans and writes are paced by
// the single read and single write port of the table.
// One item is in work at a time; the next is taken while a result waits.
// ----------------------------------------------------------------------------
module next_fit_page_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [nfpa_pkg::OP_W-1:0]     operation,
    input  logic [nfpa_pkg::SIZE_W-1:0]   size_bytes,
    input  logic [nfpa_pkg::INDEX_W-1:0]  page_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nfpa_pkg::STATUS_W-1:0] status,
    output logic [nfpa_pkg::START_W-1:0]  start_page,
    output logic [nfpa_pkg::COUNT_W-1:0]  page_count
);
    import nfpa_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ASCAN  = 3'd2;
    localparam logic [2:0] S_AWRITE = 3'd3;
    localparam logic [2:0] S_FSCAN  = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(NUM_PAGES - 1);

    typedef struct packed {
        logic [PAGE_W-1:0] addr;
        logic              live;
        logic              wrap;
    } iss_t;

    function automatic iss_t scan_succ(input logic [PAGE_W-1:0] a, input logic w);
        iss_t r;
        r.addr = a + PAGE_W'(1);
        r.live = 1'b1;
        r.wrap = w;
        if (a == LAST_PAGE)
        begin
            r.addr = '0;
            r.live = !w;
            r.wrap = 1'b1;
        end
        return r;
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [PAGE_W-1:0]   sp_reg, sp_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [CNT_W-1:0]    cand_reg, cand_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PAGE_W-1:0]   wp_reg, wp_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic [PAGE_W-1:0]   iss_addr_reg, iss_addr_next;
    logic                iss_live_reg, iss_live_next;
    logic                iss_wrap_reg, iss_wrap_next;
    logic [PAGE_W-1:0]   ev_addr_reg, ev_addr_next;
    logic                ev_vld_reg, ev_vld_next;
    logic                ev_wrap_reg, ev_wrap_next;
    logic                first_reg, first_next;
    logic [ID_BITS-1:0]  own_reg, own_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [START_W-1:0]  res_start_reg, res_start_next;
    logic [COUNT_W-1:0]  res_count_reg, res_count_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [START_W-1:0]  out_start_reg, out_start_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    logic                wr_en;
    logic [PAGE_W-1:0]   wr_addr;
    logic [ID_BITS-1:0]  wr_data;
    logic [PAGE_W-1:0]   rd_addr;
    logic [ID_BITS-1:0]  rd_data;

    logic [REQ_W-1:0]    req_in;
    logic [PAGE_W-1:0]   page_in;
    logic                page_oob;
    logic [CNT_W-1:0]    cnt_plus;
    logic [CNT_W-1:0]    ev_after;
    logic                ev_last;
    logic [CNT_W-1:0]    run_end;
    logic [ID_BITS-1:0]  id_inc;
    logic                hit;
    logic                match;
    logic [CNT_W-1:0]    cand_v;
    iss_t                adv;

    nfpa_ram #(
        .WIDTH(ID_BITS),
        .DEPTH(NUM_PAGES)
    ) u_owner_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign req_in   = REQ_W'(size_bytes >> PAGE_SHIFT)
                    + REQ_W'(|size_bytes[PAGE_SHIFT-1:0]);
    assign page_in  = PAGE_W'(page_index);
    assign page_oob = 32'(page_index) >= NUM_PAGES;
    assign cnt_plus = cnt_reg + CNT_W'(1);
    assign ev_after = CNT_W'(ev_addr_reg) + CNT_W'(1);
    assign ev_last  = ev_addr_reg == LAST_PAGE;
    assign run_end  = cand_reg + cnt_reg;
    assign id_inc   = id_reg + ID_BITS'(1);

    always_comb
    begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        id_next         = id_reg;
        req_next        = req_reg;
        cand_next       = cand_reg;
        cnt_next        = cnt_reg;
        wp_next         = wp_reg;
        left_next       = left_reg;
        iss_addr_next   = iss_addr_reg;
        iss_live_next   = iss_live_reg;
        iss_wrap_next   = iss_wrap_reg;
        ev_addr_next    = ev_addr_reg;
        ev_vld_next     = 1'b0;
        ev_wrap_next    = ev_wrap_reg;
        first_next      = first_reg;
        own_next        = own_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_count_next  = res_count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;
        wr_addr         = wp_reg;
        wr_data         = '0;
        rd_addr         = iss_addr_reg;
        hit             = 1'b0;
        match           = 1'b0;
        cand_v          = cand_reg;
        adv             = scan_succ(iss_addr_reg, iss_wrap_reg);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = wp_reg;
                wp_next = wp_reg + PAGE_W'(1);
                if (wp_reg == LAST_PAGE)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_start_next = '0;
                    res_count_next = '0;
                    if (operation == OP_ALLOC)
                    begin
                        if (req_in == '0)
                        begin
                            res_status_next = ST_NO_SPACE;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            rd_addr       = sp_reg;
                            adv           = scan_succ(sp_reg, sp_reg == '0);
                            iss_addr_next = adv.addr;
                            iss_live_next = adv.live;
                            iss_wrap_next = adv.wrap;
                            ev_addr_next  = sp_reg;
                            ev_vld_next   = 1'b1;
                            ev_wrap_next  = sp_reg == '0;
                            cand_next     = CNT_W'(sp_reg);
                            cnt_next      = '0;
                            req_next      = req_in;
                            state_next    = S_ASCAN;
                        end
                    end
                    else if (page_oob)
                    begin
                        res_status_next = ST_NOTHING;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        rd_addr       = page_in;
                        iss_addr_next = page_in + PAGE_W'(1);
                        iss_live_next = page_in != LAST_PAGE;
                        ev_addr_next  = page_in;
                        ev_vld_next   = 1'b1;
                        first_next    = 1'b1;
                        cnt_next      = '0;
                        state_next    = S_FSCAN;
                    end
                end
            end

            S_ASCAN:
            begin
                if (iss_live_reg)
                begin
                    iss_addr_next = adv.addr;
                    iss_live_next = adv.live;
                    iss_wrap_next = adv.wrap;
                    ev_addr_next  = iss_addr_reg;
                    ev_vld_next   = 1'b1;
                end
                if (ev_vld_reg)
                begin
                    if (rd_data != '0)
                    begin
                        cnt_next  = '0;
                        cand_v    = ev_after;
                        cand_next = ev_after;
                    end
                    else
                    begin
                        cnt_next = cnt_plus;
                        hit      = CMP_W'(cnt_plus) == CMP_W'(req_reg);
                    end
                    if (hit)
                    begin
                        wp_next    = PAGE_W'(cand_reg);
                        left_next  = cnt_plus;
                        state_next = S_AWRITE;
                    end
                    else if (ev_last)
                    begin
                        if (ev_wrap_reg)
                        begin
                            sp_next = (32'(cand_v) >= NUM_PAGES) ? '0 : PAGE_W'(cand_v);
                            res_status_next = ST_NO_SPACE;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            ev_wrap_next = 1'b1;
                            cand_next    = '0;
                            cnt_next     = '0;
                        end
                    end
                end
            end

            S_AWRITE:
            begin
                wr_en     = 1'b1;
                wr_addr   = wp_reg;
                wr_data   = id_reg;
                wp_next   = wp_reg + PAGE_W'(1);
                left_next = left_reg - CNT_W'(1);
                if (left_reg == CNT_W'(1))
                begin
                    sp_next = (32'(run_end) >= NUM_PAGES) ? '0 : PAGE_W'(run_end);
                    id_next = (id_inc == '0) ? ID_BITS'(1) : id_inc;
                    res_status_next = ST_ALLOCATED;
                    res_start_next  = START_W'(cand_reg);
                    res_count_next  = COUNT_W'(cnt_reg);
                    state_next      = S_RESP;
                end
            end

            S_FSCAN:
            begin
                if (iss_live_reg)
                begin
                    iss_addr_next = iss_addr_reg + PAGE_W'(1);
                    iss_live_next = iss_addr_reg != LAST_PAGE;
                    ev_addr_next  = iss_addr_reg;
                    ev_vld_next   = 1'b1;
                end
                if (ev_vld_reg)
                begin
                    first_next = 1'b0;
                    match      = first_reg ? (rd_data != '0) : (rd_data == own_reg);
                    if (first_reg)
                    begin
                        own_next = rd_data;
                    end
                    if (first_reg && rd_data == '0)
                    begin
                        res_status_next = ST_NOTHING;
                        state_next      = S_RESP;
                    end
                    else if (match)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = ev_addr_reg;
                        wr_data  = '0;
                        cnt_next = cnt_plus;
                        if (ev_last)
                        begin
                            res_status_next = ST_FREED;
                            res_count_next  = COUNT_W'(cnt_plus);
                            state_next      = S_RESP;
                        end
                    end
                    else
                    begin
                        res_status_next = ST_FREED;
                        res_count_next  = COUNT_W'(cnt_reg);
                        state_next      = S_RESP;
                    end
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = res_start_reg;
                    out_count_next  = res_count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sp_reg        <= '0;
            id_reg        <= ID_BITS'(1);
            wp_reg        <= '0;
            left_reg      <= '0;
            cand_reg      <= '0;
            cnt_reg       <= '0;
            iss_live_reg  <= 1'b0;
            iss_wrap_reg  <= 1'b0;
            ev_vld_reg    <= 1'b0;
            ev_wrap_reg   <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            id_reg        <= id_next;
            wp_reg        <= wp_next;
            left_reg      <= left_next;
            cand_reg      <= cand_next;
            cnt_reg       <= cnt_next;
            iss_live_reg  <= iss_live_next;
            iss_wrap_reg  <= iss_wrap_next;
            ev_vld_reg    <= ev_vld_next;
            ev_wrap_reg   <= ev_wrap_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        iss_addr_reg   <= iss_addr_next;
        ev_addr_reg    <= ev_addr_next;
        own_reg        <= own_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_count_reg  <= out_count_next;
    end

    assign in_stall   = state_reg != S_IDLE;
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign start_page = out_start_reg;
    assign page_count = out_count_reg;

endmodule

// File: hw/rtl/nfpa_checker.sv
// ----------------------------------------------------------------------------
// Next-fit page allocator checker
// Port-level checks of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfpa_port_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [nfpa_pkg::STATUS_W-1:0] status,
    input logic [nfpa_pkg::START_W-1:0]  start_page,
    input logic [nfpa_pkg::COUNT_W-1:0]  page_count
);
    import nfpa_pkg::*;

    // The block works on one item at a time.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(status) && $stable(start_page) && $stable(page_count))

    // Only a successful allocation reports a start page.
    `ASSERT_IMPL(a_start_only_alloc, clk, rst_n, out_valid && status != ST_ALLOCATED,
        start_page == '0)

    // Successes move at least one page, failures none.
    `ASSERT_IMPL(a_count_on_success, clk, rst_n, out_valid,
        (page_count != '0) == (status == ST_ALLOCATED || status == ST_FREED))

endmodule

bind next_fit_page_allocator nfpa_port_checker u_nfpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .start_page(start_page),
    .page_count(page_count)
);
